// ----- design/sha1_pkg.sv -----
// ----------------------------------------------------------------------------
// sha1_pkg
// shared types and constants of the sha-1 digest block
// ----------------------------------------------------------------------------
package sha1_pkg;

    localparam int WORD_W   = 32;
    localparam int WORDS    = 5;
    localparam int BLOCK_W  = 512;
    localparam int COUNT_W  = 61;
    localparam int LEN_W    = 64;
    localparam int POS_W    = 6;
    localparam int ROUND_W  = 7;
    localparam int IDX_W    = 3;

    localparam logic [ROUND_W-1:0] LAST_ROUND = 7'd79;
    localparam logic [ROUND_W-1:0] ROUND_F1   = 7'd20;
    localparam logic [ROUND_W-1:0] ROUND_F2   = 7'd40;
    localparam logic [ROUND_W-1:0] ROUND_F3   = 7'd60;

    localparam logic [POS_W-1:0] POS_FULL = 6'd63;
    localparam logic [POS_W-1:0] POS_LEN  = 6'd56;
    localparam logic [7:0]       PAD_BYTE = 8'h80;
    localparam logic [IDX_W-1:0] IDX_LAST = 3'd4;

    localparam logic [WORD_W-1:0] H_INIT [WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [WORD_W-1:0] K0 = 32'h5A827999;
    localparam logic [WORD_W-1:0] K1 = 32'h6ED9EBA1;
    localparam logic [WORD_W-1:0] K2 = 32'h8F1BBCDC;
    localparam logic [WORD_W-1:0] K3 = 32'hCA62C1D6;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] data;
        logic       is_last;
    } t_cmd;

endpackage

// ----- design/sha1_if.sv -----
// ----------------------------------------------------------------------------
// sha1 stream interfaces
// message byte channel and digest word channel
// ----------------------------------------------------------------------------
interface sha1_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       no_byte;
    logic       is_last;

    modport source (output valid, output data_byte, output no_byte, output is_last,
                    input ready);
    modport sink   (input valid, input data_byte, input no_byte, input is_last,
                    output ready);
endinterface

interface sha1_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input last_word, output ready);
endinterface

// ----- design/sha1_front.sv -----
// ----------------------------------------------------------------------------
// sha1_front
// accepts message items, drops empty non-final items, registers commands
// ----------------------------------------------------------------------------
module sha1_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sha1_in_if.sink           i_msg,
    output logic              o_push_valid,
    output sha1_pkg::t_cmd    o_push_cmd,
    input  logic              i_push_ready
);

    logic           r_valid;
    sha1_pkg::t_cmd r_cmd;
    logic           take;
    logic           keep;

    assign i_msg.ready = !r_valid || i_push_ready;
    assign take        = i_msg.valid && i_msg.ready;
    assign keep        = !i_msg.no_byte || i_msg.is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= keep;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
        if (take) begin
            r_cmd.has_byte <= !i_msg.no_byte;
            r_cmd.data     <= i_msg.data_byte;
            r_cmd.is_last  <= i_msg.is_last;
        end
    end

    assign o_push_valid = r_valid;
    assign o_push_cmd   = r_cmd;

endmodule

// ----- design/sha1_queue.sv -----
// ----------------------------------------------------------------------------
// sha1_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
module sha1_queue #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    input  sha1_pkg::t_cmd    i_push_cmd,
    output logic              o_push_ready,
    output logic              o_pop_valid,
    output sha1_pkg::t_cmd    o_pop_cmd,
    input  logic              i_pop_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sha1_pkg::t_cmd   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             push;
    logic             pop;

    assign o_push_ready = r_cnt != CNT_W'(DEPTH);
    assign o_pop_valid  = r_cnt != '0;
    assign o_pop_cmd    = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (push) begin
            r_mem[r_wr] <= i_push_cmd;
        end
    end

endmodule

// ----- design/sha1_back.sv -----
// ----------------------------------------------------------------------------
// sha1_back
// block packing, padding, 80-round compression and digest output
// ----------------------------------------------------------------------------
module sha1_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_pop_valid,
    input  sha1_pkg::t_cmd    i_pop_cmd,
    output logic              o_pop_ready,
    sha1_out_if.source        o_digest
);

    typedef enum logic [2:0] {ST_IDLE, ST_PAD, ST_ROUND, ST_FOLD, ST_OUT} t_state;
    typedef enum logic [1:0] {PAD_MARK, PAD_ZERO, PAD_LEN, PAD_DONE} t_pad;

    localparam int W = sha1_pkg::WORD_W;

    t_state                         r_state, n_state;
    t_pad                           r_pad, n_pad;
    logic                           r_pad_on, n_pad_on;
    logic [2:0]                     r_len_cnt, n_len_cnt;
    logic [sha1_pkg::LEN_W-1:0]     r_len, n_len;
    logic [sha1_pkg::COUNT_W-1:0]   r_count, n_count;
    logic [sha1_pkg::POS_W-1:0]     r_pos, n_pos;
    logic [sha1_pkg::BLOCK_W-1:0]   r_block, n_block;
    logic [W-1:0]                   r_h [sha1_pkg::WORDS];
    logic [W-1:0]                   n_h [sha1_pkg::WORDS];
    logic [W-1:0]                   r_wv [sha1_pkg::WORDS];
    logic [W-1:0]                   n_wv [sha1_pkg::WORDS];
    logic [sha1_pkg::ROUND_W-1:0]   r_round, n_round;
    logic [sha1_pkg::IDX_W-1:0]     r_idx, n_idx;

    logic                           ab_en;
    logic [7:0]                     ab_byte;
    logic [sha1_pkg::POS_W-1:0]     pos_inc;
    logic [W-1:0]                   f_val, k_val, w_new, t_sum;
    logic [W-1:0]                   wa, wb, wc, wd, we;

    assign pos_inc = r_pos + 1'b1;
    assign wa = r_wv[0];
    assign wb = r_wv[1];
    assign wc = r_wv[2];
    assign wd = r_wv[3];
    assign we = r_wv[4];

    // round function and schedule expansion
    always_comb begin
        if (r_round < sha1_pkg::ROUND_F1) begin
            f_val = (wb & wc) | (~wb & wd);
            k_val = sha1_pkg::K0;
        end else if (r_round < sha1_pkg::ROUND_F2) begin
            f_val = wb ^ wc ^ wd;
            k_val = sha1_pkg::K1;
        end else if (r_round < sha1_pkg::ROUND_F3) begin
            f_val = (wb & wc) | (wb & wd) | (wc & wd);
            k_val = sha1_pkg::K2;
        end else begin
            f_val = wb ^ wc ^ wd;
            k_val = sha1_pkg::K3;
        end
        w_new = r_block[95:64] ^ r_block[255:224] ^ r_block[447:416] ^ r_block[511:480];
        w_new = {w_new[30:0], w_new[31]};
        t_sum = {wa[26:0], wa[31:27]} + f_val + we + k_val + r_block[511:480];
    end

    always_comb begin
        n_state   = r_state;
        n_pad     = r_pad;
        n_pad_on  = r_pad_on;
        n_len_cnt = r_len_cnt;
        n_len     = r_len;
        n_count   = r_count;
        n_pos     = r_pos;
        n_block   = r_block;
        n_h       = r_h;
        n_wv      = r_wv;
        n_round   = r_round;
        n_idx     = r_idx;
        ab_en     = 1'b0;
        ab_byte   = 8'h00;
        o_pop_ready = 1'b0;

        case (r_state)
            ST_IDLE: begin
                o_pop_ready = 1'b1;
                if (i_pop_valid) begin
                    if (i_pop_cmd.has_byte) begin
                        ab_en   = 1'b1;
                        ab_byte = i_pop_cmd.data;
                        n_count = r_count + 1'b1;
                    end
                    if (i_pop_cmd.is_last) begin
                        n_pad_on  = 1'b1;
                        n_pad     = PAD_MARK;
                        n_len_cnt = '0;
                        n_len     = {n_count, 3'b000};
                        n_state   = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                ab_en = 1'b1;
                case (r_pad)
                    PAD_MARK: begin
                        ab_byte = sha1_pkg::PAD_BYTE;
                        n_pad   = (pos_inc == sha1_pkg::POS_LEN) ? PAD_LEN : PAD_ZERO;
                    end
                    PAD_ZERO: begin
                        ab_byte = 8'h00;
                        n_pad   = (pos_inc == sha1_pkg::POS_LEN) ? PAD_LEN : PAD_ZERO;
                    end
                    PAD_LEN: begin
                        ab_byte   = r_len[63:56];
                        n_len     = {r_len[55:0], 8'h00};
                        n_len_cnt = r_len_cnt + 1'b1;
                        if (r_len_cnt == 3'd7) begin
                            n_pad = PAD_DONE;
                        end
                    end
                    default: begin
                        ab_en = 1'b0;
                    end
                endcase
            end
            ST_ROUND: begin
                n_wv[0] = t_sum;
                n_wv[1] = wa;
                n_wv[2] = {wb[1:0], wb[31:2]};
                n_wv[3] = wc;
                n_wv[4] = wd;
                n_block = {r_block[479:0], w_new};
                if (r_round == sha1_pkg::LAST_ROUND) begin
                    n_round = '0;
                    n_state = ST_FOLD;
                end else begin
                    n_round = r_round + 1'b1;
                end
            end
            ST_FOLD: begin
                for (int i = 0; i < sha1_pkg::WORDS; i++) begin
                    n_h[i] = r_h[i] + r_wv[i];
                end
                if (!r_pad_on) begin
                    n_state = ST_IDLE;
                end else if (r_pad == PAD_DONE) begin
                    n_idx   = '0;
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_PAD;
                end
            end
            ST_OUT: begin
                if (o_digest.ready) begin
                    for (int i = 0; i < sha1_pkg::WORDS - 1; i++) begin
                        n_h[i] = r_h[i + 1];
                    end
                    n_h[sha1_pkg::WORDS - 1] = r_h[0];
                    n_idx = r_idx + 1'b1;
                    if (r_idx == sha1_pkg::IDX_LAST) begin
                        n_h      = sha1_pkg::H_INIT;
                        n_count  = '0;
                        n_pos    = '0;
                        n_pad_on = 1'b0;
                        n_idx    = '0;
                        n_state  = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // byte into the block, start compression when full
        if (ab_en) begin
            n_block = {r_block[503:0], ab_byte};
            n_pos   = pos_inc;
            if (r_pos == sha1_pkg::POS_FULL) begin
                n_wv    = r_h;
                n_round = '0;
                n_state = ST_ROUND;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pad    <= PAD_MARK;
            r_pad_on <= 1'b0;
            r_count  <= '0;
            r_pos    <= '0;
            r_round  <= '0;
            r_idx    <= '0;
            r_h      <= sha1_pkg::H_INIT;
        end else begin
            r_state  <= n_state;
            r_pad    <= n_pad;
            r_pad_on <= n_pad_on;
            r_count  <= n_count;
            r_pos    <= n_pos;
            r_round  <= n_round;
            r_idx    <= n_idx;
            r_h      <= n_h;
        end
        r_len_cnt <= n_len_cnt;
        r_len     <= n_len;
        r_block   <= n_block;
        r_wv      <= n_wv;
    end

    assign o_digest.valid       = r_state == ST_OUT;
    assign o_digest.digest_word = r_h[0];
    assign o_digest.word_index  = r_idx;
    assign o_digest.last_word   = r_idx == sha1_pkg::IDX_LAST;

    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_round <= sha1_pkg::LAST_ROUND)
        else $error("round counter out of range");

    a_len_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PAD && r_pad == PAD_LEN) |-> r_pos >= sha1_pkg::POS_LEN)
        else $error("length bytes outside block tail");

    a_reinit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_digest.valid && o_digest.ready && o_digest.last_word)
        |=> (r_count == '0 && r_pos == '0 && r_state == ST_IDLE))
        else $error("no reinitialise after digest");

    a_round_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_ROUND) |-> r_round == '0)
        else $error("round counter not at rest");

endmodule

// ----- design/sha1_message_digest.sv -----
// ----------------------------------------------------------------------------
// sha1_message_digest
// sha-1 digest of a byte stream, one byte per item
// ----------------------------------------------------------------------------
// i_msg carries data_byte, no_byte and is_last; an item is taken when valid
// and ready are both high. an item with no_byte set and is_last clear is
// taken and ignored. on the last item the block pads the message, finishes
// the compression and sends h0..h4 on o_digest as five items, word_index
// 0 to 4, last_word set on the fifth.
// items enter a registered front stage and a short command queue, so bytes
// are taken one per cycle while the queue has room. the back takes one byte
// per cycle while idle; every 64th byte starts the compression, 80 rounds
// and then a fold into the chaining words, during which no byte is taken.
// padding appends 9 to 72 fill bytes plus one or two compressions, then the
// digest words leave one per cycle while the receiver is ready.
// a stalled receiver holds the current digest word; the back waits and the
// queue and front fill up and then drop ready. synchronous reset loads the
// initial chaining words and empties the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sha1_message_digest #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sha1_in_if.sink     i_msg,
    sha1_out_if.source  o_digest
);

    logic           push_valid;
    logic           push_ready;
    sha1_pkg::t_cmd push_cmd;
    logic           pop_valid;
    logic           pop_ready;
    sha1_pkg::t_cmd pop_cmd;

    sha1_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_msg        (i_msg),
        .o_push_valid (push_valid),
        .o_push_cmd   (push_cmd),
        .i_push_ready (push_ready)
    );

    sha1_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_cmd   (push_cmd),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_cmd    (pop_cmd),
        .i_pop_ready  (pop_ready)
    );

    sha1_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .i_pop_cmd   (pop_cmd),
        .o_pop_ready (pop_ready),
        .o_digest    (o_digest)
    );

endmodule
